// ----- rtl/ssp_pkg.sv -----
package ssp_pkg;

    localparam int DEF_MAX_ORDER   = 16;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_VAR_BITS    = 32;

    // max_order register
    localparam int              CFG_BITS  = 5;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Q16 blend weights
    localparam int               FRAC_BITS = 16;
    localparam int               WGT_BITS  = FRAC_BITS + 1;
    localparam logic [WGT_BITS-1:0] WGT_ONE  = WGT_BITS'(1) << FRAC_BITS;
    localparam logic [WGT_BITS-1:0] WGT_HALF = WGT_BITS'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic blend;   // buffered entries are blended, else passed raw
        logic tail;    // current sample follows the buffered entries
    } t_cmd_flg;

endpackage

// ----- rtl/ssp_in_if.sv -----
interface ssp_in_if import ssp_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int VAR_BITS    = DEF_VAR_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          detected;
    logic signed [SAMPLE_BITS-1:0] fwd_pred;
    logic signed [SAMPLE_BITS-1:0] bwd_pred;
    logic        [VAR_BITS-1:0]    fwd_var;
    logic        [VAR_BITS-1:0]    bwd_var;
    logic                          block_last;

    modport source (
        output valid, in_sample, detected, fwd_pred, bwd_pred, fwd_var, bwd_var, block_last,
        input  ready
    );
    modport sink (
        input  valid, in_sample, detected, fwd_pred, bwd_pred, fwd_var, bwd_var, block_last,
        output ready
    );
endinterface

// ----- rtl/ssp_out_if.sv -----
interface ssp_out_if import ssp_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          replaced;
    logic                          run_last;

    modport source (output valid, out_sample, replaced, run_last, input ready);
    modport sink   (input  valid, out_sample, replaced, run_last, output ready);
endinterface

// ----- rtl/spike_segment_predictor_blend_core.sv -----
// Channel   Dir  Handshake      Payload
// i_in      in   valid / ready  in_sample, detected, fwd_pred, bwd_pred, fwd_var, bwd_var,
//                               block_last
// o_out     out  valid / ready  out_sample, replaced, run_last
// i_cfg     in   we only        max_order (5 bits)
//
// Back end: a pass-through sample is popped, then output.
// Each sample of a buffered run is read, multiplied, then summed/saturated; blended runs
// with a nonzero forward variance first pass through the bit-serial weight divider.
// Reset: synchronous active-low i_rst_n; run buffer has no reset and no clearing pass.
// Stalls: input stalls when the command queue is full or a run is being drained.
module spike_segment_predictor_blend_core import ssp_pkg::*; #(
    parameter int MAX_ORDER   = DEF_MAX_ORDER,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int VAR_BITS    = DEF_VAR_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    ssp_in_if.sink              i_in,
    ssp_out_if.source           o_out
);
    localparam int BUF_DEPTH = 2 * MAX_ORDER + 3;   // longest replaceable run
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int AW        = $clog2(BUF_DEPTH);
    localparam int CMD_W     = CNT_W + 2 + SAMPLE_BITS + 2 * VAR_BITS;

    // front -> queue
    logic                     push;
    logic [CNT_W-1:0]         cmd_cnt;
    t_cmd_flg                 cmd_flg;
    logic [SAMPLE_BITS-1:0]   cmd_smp;
    logic [VAR_BITS-1:0]      cmd_vf, cmd_vb;

    // front -> run buffer in back
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [3*SAMPLE_BITS-1:0] wr_data;

    // queue <-> back, and back -> front
    logic                     pop, full, empty;
    logic [CMD_W-1:0]         q_out;
    logic                     buf_free;

    ssp_front #(
        .MAX_ORDER(MAX_ORDER), .SAMPLE_BITS(SAMPLE_BITS), .VAR_BITS(VAR_BITS),
        .BUF_DEPTH(BUF_DEPTH), .CNT_W(CNT_W), .AW(AW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in(i_in),
        .i_full(full), .i_buf_free(buf_free),
        .o_push(push), .o_cmd_cnt(cmd_cnt), .o_cmd_flg(cmd_flg),
        .o_cmd_smp(cmd_smp), .o_cmd_vf(cmd_vf), .o_cmd_vb(cmd_vb),
        .o_wr_en(wr_en), .o_wr_addr(wr_addr), .o_wr_data(wr_data)
    );

    // decouples classification from the blend engine
    ssp_fifo #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data({cmd_cnt, cmd_flg, cmd_smp, cmd_vf, cmd_vb}),
        .i_pop(pop), .o_data(q_out),
        .o_full(full), .o_empty(empty)
    );

    ssp_back #(
        .MAX_ORDER(MAX_ORDER), .SAMPLE_BITS(SAMPLE_BITS), .VAR_BITS(VAR_BITS),
        .BUF_DEPTH(BUF_DEPTH), .CNT_W(CNT_W), .AW(AW), .CMD_W(CMD_W)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_data(wr_data),
        .i_empty(empty), .i_cmd(q_out),
        .o_pop(pop), .o_buf_free(buf_free),
        .o_out(o_out)
    );
endmodule

// ----- rtl/ssp_fifo.sv -----
module ssp_fifo import ssp_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wp, r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[AW-1:0] == r_rp[AW-1:0]) && (r_wp[AW] != r_rp[AW]);
    assign o_data  = r_mem[r_rp[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[AW-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end
endmodule

// ----- rtl/ssp_front.sv -----
module ssp_front import ssp_pkg::*; #(
    parameter int MAX_ORDER   = DEF_MAX_ORDER,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int VAR_BITS    = DEF_VAR_BITS,
    parameter int BUF_DEPTH   = 2 * MAX_ORDER + 3,
    parameter int CNT_W       = $clog2(BUF_DEPTH + 1),
    parameter int AW          = $clog2(BUF_DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_BITS-1:0]      i_cfg_data,
    ssp_in_if.sink                   i_in,
    input  logic                     i_full,
    input  logic                     i_buf_free,
    output logic                     o_push,
    output logic [CNT_W-1:0]         o_cmd_cnt,
    output t_cmd_flg                 o_cmd_flg,
    output logic [SAMPLE_BITS-1:0]   o_cmd_smp,
    output logic [VAR_BITS-1:0]      o_cmd_vf,
    output logic [VAR_BITS-1:0]      o_cmd_vb,
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output logic [3*SAMPLE_BITS-1:0] o_wr_data
);
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_BUF  = 2'd1;
    localparam logic [1:0] MODE_LONG = 2'd2;
    localparam int         CMP_W     = CFG_BITS + CNT_W + 1;

    logic [CFG_BITS-1:0] r_max_order;
    logic [1:0]          r_mode, n_mode;
    logic                r_prev_det, r_block_first, n_block_first;
    logic [VAR_BITS-1:0] r_prev_fv, r_run_fv, n_run_fv;
    logic [CNT_W-1:0]    r_len, n_len;
    logic                r_buf_busy;

    logic                accept, rise, too_long;
    logic [CFG_BITS-1:0] ord;
    logic [CFG_BITS:0]   lim;

    assign i_in.ready = !i_full && !r_buf_busy;
    assign accept     = i_in.valid && i_in.ready;
    assign rise       = i_in.detected && !r_prev_det;

    assign ord = (r_max_order > CFG_BITS'(MAX_ORDER)) ? CFG_BITS'(MAX_ORDER) : r_max_order;
    assign lim = {ord, 1'b0} + (CFG_BITS + 1)'(3);
    assign too_long = (CMP_W'(r_len) >= CMP_W'(lim)) || (r_len >= CNT_W'(BUF_DEPTH));

    assign o_cmd_smp = i_in.in_sample;
    assign o_cmd_vf  = r_run_fv;
    assign o_cmd_vb  = i_in.bwd_var;
    assign o_wr_data = {i_in.in_sample, i_in.fwd_pred, i_in.bwd_pred};

    always_comb begin
        logic push_c, wr_c;
        push_c         = 1'b1;
        wr_c           = 1'b0;
        o_cmd_cnt      = '0;
        o_cmd_flg      = '{blend: 1'b0, tail: 1'b1};
        o_wr_addr      = '0;
        n_mode         = r_mode;
        n_len          = r_len;
        n_run_fv       = r_run_fv;
        if (r_block_first) begin
            n_mode = MODE_IDLE;
        end else begin
            case (r_mode)
                MODE_IDLE: begin
                    if (rise) begin
                        push_c   = 1'b0;
                        wr_c     = 1'b1;
                        n_len    = CNT_W'(1);
                        n_run_fv = r_prev_fv;
                        n_mode   = MODE_BUF;
                    end
                end
                MODE_BUF: begin
                    if (!i_in.detected) begin
                        o_cmd_cnt       = r_len;
                        o_cmd_flg.blend = 1'b1;
                        n_mode          = MODE_IDLE;
                        n_len           = '0;
                    end else if (too_long) begin
                        o_cmd_cnt = r_len;
                        n_mode    = MODE_LONG;
                        n_len     = '0;
                    end else begin
                        push_c    = 1'b0;
                        wr_c      = 1'b1;
                        o_wr_addr = r_len[AW-1:0];
                        n_len     = r_len + 1'b1;
                    end
                end
                default: begin
                    if (!i_in.detected) begin
                        n_mode = MODE_IDLE;
                    end
                end
            endcase
        end
        // block end flushes an open run unchanged
        if (i_in.block_last) begin
            if (n_mode == MODE_BUF) begin
                push_c         = 1'b1;
                o_cmd_cnt      = n_len;
                o_cmd_flg.tail = 1'b0;
                n_len          = '0;
            end
            n_mode        = MODE_IDLE;
            n_block_first = 1'b1;
        end else begin
            n_block_first = 1'b0;
        end
        o_push  = accept && push_c;
        o_wr_en = accept && wr_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_order   <= CFG_RESET;
            r_mode        <= MODE_IDLE;
            r_prev_det    <= 1'b0;
            r_block_first <= 1'b1;
            r_prev_fv     <= '0;
            r_run_fv      <= '0;
            r_len         <= '0;
            r_buf_busy    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_order <= i_cfg_data;
            end
            if (accept) begin
                r_mode        <= n_mode;
                r_prev_det    <= i_in.detected;
                r_block_first <= n_block_first;
                r_prev_fv     <= i_in.fwd_var;
                r_run_fv      <= n_run_fv;
                r_len         <= n_len;
            end
            if (o_push && (o_cmd_cnt != '0)) begin
                r_buf_busy <= 1'b1;
            end else if (i_buf_free) begin
                r_buf_busy <= 1'b0;
            end
        end
    end
endmodule

// ----- rtl/ssp_back.sv -----
module ssp_back import ssp_pkg::*; #(
    parameter int MAX_ORDER   = DEF_MAX_ORDER,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int VAR_BITS    = DEF_VAR_BITS,
    parameter int BUF_DEPTH   = 2 * MAX_ORDER + 3,
    parameter int CNT_W       = $clog2(BUF_DEPTH + 1),
    parameter int AW          = $clog2(BUF_DEPTH),
    parameter int CMD_W       = CNT_W + 2 + SAMPLE_BITS + 2 * VAR_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [3*SAMPLE_BITS-1:0] i_wr_data,
    input  logic                     i_empty,
    input  logic [CMD_W-1:0]         i_cmd,
    output logic                     o_pop,
    output logic                     o_buf_free,
    ssp_out_if.source                o_out
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_RND  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_SUM  = 3'd5;
    localparam logic [2:0] ST_TAIL = 3'd6;

    localparam int S  = SAMPLE_BITS;
    localparam int PW = S + 18;
    localparam int AC = S + 19;

    logic [3*S-1:0] r_mem [BUF_DEPTH];

    logic [2:0]          r_state;
    logic [CNT_W-1:0]    r_cnt, r_idx;
    t_cmd_flg            r_flg;
    logic [S-1:0]        r_smp;
    logic [VAR_BITS:0]   r_sum, r_rem;
    logic [FRAC_BITS-1:0] r_q;
    logic [3:0]          r_step;
    logic [WGT_BITS-1:0] r_wf;
    logic [3*S-1:0]      r_rd;
    logic signed [PW-1:0] r_pf, r_pb;
    logic                r_ov;
    logic [S-1:0]        r_osmp;
    logic                r_orep, r_olast;

    // command fields
    logic [CNT_W-1:0]    c_cnt;
    t_cmd_flg            c_flg;
    logic [S-1:0]        c_smp;
    logic [VAR_BITS-1:0] c_vf, c_vb;
    logic [VAR_BITS:0]   c_sum;

    logic                slot_free, last_ent;
    logic [VAR_BITS+1:0] rem2;
    logic                ge;
    logic [WGT_BITS-1:0] wb;
    logic signed [AC-1:0] acc;
    logic signed [S+2:0]  qv;
    logic [S-1:0]         blended;

    assign {c_cnt, c_flg, c_smp, c_vf, c_vb} = i_cmd;
    assign c_sum = {1'b0, c_vf} + {1'b0, c_vb};

    assign slot_free = !r_ov || o_out.ready;
    assign last_ent  = (r_idx == r_cnt - 1'b1);
    assign o_pop     = (r_state == ST_IDLE) && !i_empty;
    assign o_buf_free = (r_state == ST_SUM) && slot_free && last_ent;

    assign rem2 = {r_rem, 1'b0};
    assign ge   = rem2 >= {1'b0, r_sum};
    assign wb   = WGT_ONE - r_wf;

    // floor((wf*f + wb*b + half) / 2^16), saturated
    assign acc = AC'(r_pf) + AC'(r_pb) + AC'(WGT_HALF);
    assign qv  = (S + 3)'(acc >>> FRAC_BITS);
    always_comb begin
        if (qv > (S + 3)'($signed({1'b0, {(S-1){1'b1}}}))) begin
            blended = {1'b0, {(S-1){1'b1}}};
        end else if (qv < (S + 3)'($signed({1'b1, {(S-1){1'b0}}}))) begin
            blended = {1'b1, {(S-1){1'b0}}};
        end else begin
            blended = qv[S-1:0];
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_sample = r_osmp;
    assign o_out.replaced   = r_orep;
    assign o_out.run_last   = r_olast;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (r_state == ST_RD) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if ((r_state == ST_SUM || r_state == ST_TAIL) && slot_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        if (c_cnt == '0) begin
                            r_state <= ST_TAIL;
                        end else if (c_flg.blend && (c_sum != '0) && (c_vf != '0)) begin
                            r_state <= ST_DIV;
                        end else begin
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_DIV: begin
                    if (r_step == 4'd15) begin
                        r_state <= ST_RND;
                    end
                end
                ST_RND:  r_state <= ST_RD;
                ST_RD:   r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_SUM;
                ST_SUM: begin
                    if (slot_free) begin
                        if (!last_ent) begin
                            r_state <= ST_RD;
                        end else if (r_flg.tail) begin
                            r_state <= ST_TAIL;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_TAIL: begin
                    if (slot_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cnt  <= c_cnt;
                r_flg  <= c_flg;
                r_smp  <= c_smp;
                r_sum  <= c_sum;
                r_rem  <= {1'b0, c_vb};
                r_q    <= '0;
                r_step <= '0;
                r_idx  <= '0;
                r_wf   <= (c_sum == '0) ? WGT_HALF : WGT_ONE;
            end
            ST_DIV: begin
                r_rem  <= ge ? (VAR_BITS+1)'(rem2 - {1'b0, r_sum}) : rem2[VAR_BITS:0];
                r_q    <= {r_q[FRAC_BITS-2:0], ge};
                r_step <= r_step + 1'b1;
            end
            ST_RND: begin
                r_wf <= {1'b0, r_q} + WGT_BITS'(ge);
            end
            ST_MUL: begin
                r_pf <= $signed({1'b0, r_wf}) * $signed(r_rd[2*S-1:S]);
                r_pb <= $signed({1'b0, wb}) * $signed(r_rd[S-1:0]);
            end
            ST_SUM: begin
                if (slot_free) begin
                    r_osmp  <= r_flg.blend ? blended : r_rd[3*S-1:2*S];
                    r_orep  <= r_flg.blend;
                    r_olast <= last_ent && !r_flg.tail;
                    r_idx   <= r_idx + 1'b1;
                end
            end
            ST_TAIL: begin
                if (slot_free) begin
                    r_osmp  <= r_smp;
                    r_orep  <= 1'b0;
                    r_olast <= 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule
